// File: rtl/core/swm_pkg.sv
// shared constants and types for the sliding window median filter
package swm_pkg;

  localparam int MAX_WINDOW   = 16;
  localparam int SAMPLE_WIDTH = 16;
  localparam int CFG_WIDTH    = 5;
  localparam int AGE_WIDTH    = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int LEN_WIDTH    = $clog2(MAX_WINDOW + 1);
  localparam int IDX_WIDTH    = AGE_WIDTH;

  typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
  typedef logic [AGE_WIDTH-1:0] age_t;
  typedef logic [LEN_WIDTH-1:0] len_t;
  typedef logic [CFG_WIDTH-1:0] cfg_t;

  typedef struct packed {
    sample_t val;
    age_t    age;
    logic    vld;
  } swm_entry_t;

  typedef struct packed {
    logic    step;
    logic    wipe;
    logic    kill;
    logic    full;
    age_t    old_age;
    sample_t sample;
  } swm_ctrl_t;

endpackage

// File: rtl/core/swm_if.sv
// stream interfaces for sample words and median words
interface swm_smp_if;
  import swm_pkg::*;
  logic    valid;
  logic    ready;
  sample_t sample;
  logic    start_req;
  modport source (output valid, output sample, output start_req, input ready);
  modport sink (input valid, input sample, input start_req, output ready);
endinterface

interface swm_med_if;
  import swm_pkg::*;
  logic    valid;
  logic    ready;
  sample_t median_value;
  modport source (output valid, output median_value, input ready);
  modport sink (input valid, input median_value, output ready);
endinterface

// File: rtl/core/swm_cell.sv
// one cell of the sorted window: holds a sample and its age
module swm_cell (
  input  logic                clk,
  input  logic                rst,
  input  swm_pkg::swm_ctrl_t  ctrl,
  input  swm_pkg::swm_entry_t up_st,
  input  swm_pkg::swm_entry_t lo_prime,
  input  logic                lo_above,
  input  logic                rm_in,
  output swm_pkg::swm_entry_t prime,
  output logic                above,
  output logic                rm_out,
  output swm_pkg::swm_entry_t nxt,
  output swm_pkg::swm_entry_t held
);
  import swm_pkg::*;

  swm_entry_t st;
  swm_entry_t cur_e;
  swm_entry_t up_e;
  logic       hit;

  assign held = st;

  always_comb begin
    cur_e = st;
    cur_e.vld = st.vld & ~ctrl.kill;
    up_e = up_st;
    up_e.vld = up_st.vld & ~ctrl.kill;
    hit = cur_e.vld && ctrl.full && (st.age == ctrl.old_age);
    rm_out = rm_in | hit;
    prime = rm_out ? up_e : cur_e;
    above = !prime.vld || (ctrl.sample < prime.val);
    if (above) begin
      if (lo_above) begin
        nxt = lo_prime;
        nxt.age = lo_prime.age + 1'b1;
      end else begin
        nxt.val = ctrl.sample;
        nxt.age = '0;
        nxt.vld = 1'b1;
      end
    end else begin
      nxt = prime;
      nxt.age = prime.age + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctrl.wipe) begin
      st.vld <= 1'b0;
    end else if (ctrl.step) begin
      st.vld <= nxt.vld;
    end
    if (ctrl.step) begin
      st.val <= nxt.val;
      st.age <= nxt.age;
    end
  end

endmodule

// File: rtl/core/sliding_window_median.sv
// sliding window median top level: one sample word in, one lower median word out
// a median word appears in the cycle after the sample word that completes it is taken
// throughput: one sample word per cycle unless the median output is stalled
// a median word held back by the receiver stalls the sample input until it is taken
// reset: synchronous, empties the window and the output register, window length 16
module sliding_window_median (
  input logic              clk,
  input logic              rst,
  swm_smp_if.sink          smp,
  swm_med_if.source        med,
  input logic              cfg_we,
  input swm_pkg::cfg_t     cfg_wdata
);
  import swm_pkg::*;

  len_t       len;
  len_t       fill;
  len_t       fill_eff;
  len_t       fill_next;
  len_t       len_m1;
  logic       step;
  logic       full;
  logic [IDX_WIDTH-1:0] mid;
  swm_ctrl_t  ctrl;
  swm_entry_t prime [MAX_WINDOW];
  swm_entry_t nxt [MAX_WINDOW];
  swm_entry_t cells [MAX_WINDOW];
  logic       above [MAX_WINDOW];
  logic       rm [MAX_WINDOW];

  assign smp.ready = !med.valid || med.ready;
  assign step = smp.valid && smp.ready;

  always_comb begin
    fill_eff = smp.start_req ? '0 : fill;
    full = (fill_eff == len);
    fill_next = full ? fill_eff : fill_eff + 1'b1;
    len_m1 = len - 1'b1;
    mid = IDX_WIDTH'(len_m1 >> 1);
    ctrl.step = step;
    ctrl.wipe = cfg_we;
    ctrl.kill = smp.start_req;
    ctrl.full = full;
    ctrl.old_age = AGE_WIDTH'(len_m1);
    ctrl.sample = smp.sample;
  end

  for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
    swm_entry_t up_st;
    swm_entry_t lo_prime;
    logic       lo_above;
    logic       rm_in;

    if (i == MAX_WINDOW - 1) begin : g_top
      assign up_st = '0;
    end else begin : g_mid
      assign up_st = cells[i+1];
    end

    if (i == 0) begin : g_first
      assign lo_prime = '0;
      assign lo_above = 1'b0;
      assign rm_in = 1'b0;
    end else begin : g_rest
      assign lo_prime = prime[i-1];
      assign lo_above = above[i-1];
      assign rm_in = rm[i-1];
    end

    swm_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctrl     (ctrl),
      .up_st    (up_st),
      .lo_prime (lo_prime),
      .lo_above (lo_above),
      .rm_in    (rm_in),
      .prime    (prime[i]),
      .above    (above[i]),
      .rm_out   (rm[i]),
      .nxt      (nxt[i]),
      .held     (cells[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      len <= LEN_WIDTH'(MAX_WINDOW);
      fill <= '0;
      med.valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_wdata == '0) begin
          len <= LEN_WIDTH'(1);
        end else if (int'(cfg_wdata) > MAX_WINDOW) begin
          len <= LEN_WIDTH'(MAX_WINDOW);
        end else begin
          len <= LEN_WIDTH'(cfg_wdata);
        end
        fill <= '0;
      end else if (step) begin
        fill <= fill_next;
      end
      if (step) begin
        med.valid <= (fill_next == len);
      end else if (med.ready) begin
        med.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      med.median_value <= nxt[mid].val;
    end
  end

endmodule

// File: rtl/core/swm_checker.sv
// port-level checks for the sliding window median filter, bound to the top level
module swm_checker (
  input logic              clk,
  input logic              rst,
  input logic              smp_valid,
  input logic              smp_ready,
  input logic              med_valid,
  input logic              med_ready,
  input swm_pkg::sample_t  med_value
);
  import swm_pkg::*;

  a_rst_empty: assert property (@(posedge clk) rst |=> !med_valid)
    else $error("median word valid after reset");

  a_rise_from_accept: assert property (@(posedge clk) disable iff (rst)
    $rose(med_valid) |-> $past(smp_valid && smp_ready))
    else $error("median word without an accepted sample word");

  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    (med_valid && !med_ready) |-> !smp_ready)
    else $error("sample word taken while output stalled");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (med_valid && !med_ready) |=> (med_valid && $stable(med_value)))
    else $error("stalled median word changed");

endmodule

bind sliding_window_median swm_checker u_swm_checker (
  .clk       (clk),
  .rst       (rst),
  .smp_valid (smp.valid),
  .smp_ready (smp.ready),
  .med_valid (med.valid),
  .med_ready (med.ready),
  .med_value (med.median_value)
);

// File: tb/sv/tb.sv
// testbench for the sliding window median filter: directed table, random streams, median scoreboard
module tb;
  import swm_pkg::*;

  localparam int HOLD_CYCLES = 300;
  localparam int STALL_LIMIT = 4000;
  localparam int N_PHASES    = 12;
  localparam int PHASE_ITEMS = 130;
  localparam int N_ROWS      = 29;

  typedef struct packed {
    logic    is_cfg;
    cfg_t    win;
    sample_t smp;
    logic    st;
    logic    typed;
    sample_t med;
  } dir_row_t;

  // is_cfg, window, sample, start, typed, median
  localparam dir_row_t DIR_TAB [N_ROWS] = '{
    '{1'b0, 5'd0,  16'sh8000, 1'b1, 1'b0, 16'sh0000},
    '{1'b0, 5'd0,  16'sh7fff, 1'b0, 1'b0, 16'sh0000},
    '{1'b0, 5'd0,  16'sh8000, 1'b0, 1'b0, 16'sh0000},
    '{1'b0, 5'd0,  16'sh7fff, 1'b0, 1'b0, 16'sh0000},
    '{1'b0, 5'd0,  16'sh8000, 1'b0, 1'b0, 16'sh0000},
    '{1'b0, 5'd0,  16'sh7fff, 1'b0, 1'b0, 16'sh0000},
    '{1'b0, 5'd0,  16'sh8000, 1'b0, 1'b0, 16'sh0000},
    '{1'b0, 5'd0,  16'sh7fff, 1'b0, 1'b0, 16'sh0000},
    '{1'b0, 5'd0,  16'sh8000, 1'b0, 1'b0, 16'sh0000},
    '{1'b0, 5'd0,  16'sh7fff, 1'b0, 1'b0, 16'sh0000},
    '{1'b0, 5'd0,  16'sh8000, 1'b0, 1'b0, 16'sh0000},
    '{1'b0, 5'd0,  16'sh7fff, 1'b0, 1'b0, 16'sh0000},
    '{1'b0, 5'd0,  16'sh8000, 1'b0, 1'b0, 16'sh0000},
    '{1'b0, 5'd0,  16'sh7fff, 1'b0, 1'b0, 16'sh0000},
    '{1'b0, 5'd0,  16'sh8000, 1'b0, 1'b0, 16'sh0000},
    '{1'b0, 5'd0,  16'sh7fff, 1'b0, 1'b1, 16'sh8000},
    '{1'b0, 5'd0,  16'sh7fff, 1'b0, 1'b1, 16'sh7fff},
    '{1'b1, 5'd1,  16'sh0000, 1'b0, 1'b0, 16'sh0000},
    '{1'b0, 5'd0,  16'sh0000, 1'b0, 1'b1, 16'sh0000},
    '{1'b0, 5'd0,  16'shffff, 1'b1, 1'b1, 16'shffff},
    '{1'b0, 5'd0,  16'sh5555, 1'b0, 1'b1, 16'sh5555},
    '{1'b1, 5'd0,  16'sh0000, 1'b0, 1'b0, 16'sh0000},
    '{1'b0, 5'd0,  16'sh2aaa, 1'b0, 1'b1, 16'sh2aaa},
    '{1'b1, 5'd3,  16'sh0000, 1'b0, 1'b0, 16'sh0000},
    '{1'b0, 5'd0,  16'sd5,    1'b0, 1'b0, 16'sh0000},
    '{1'b0, 5'd0,  -16'sd7,   1'b0, 1'b0, 16'sh0000},
    '{1'b0, 5'd0,  16'sd5,    1'b0, 1'b1, 16'sd5},
    '{1'b0, 5'd0,  16'sd5,    1'b0, 1'b1, 16'sd5},
    '{1'b0, 5'd0,  -16'sd7,   1'b1, 1'b0, 16'sh0000}
  };

  logic clk;
  logic rst;
  logic cfg_we;
  cfg_t cfg_wdata;

  swm_smp_if smp_ch();
  swm_med_if med_ch();

  sliding_window_median dut (
    .clk       (clk),
    .rst       (rst),
    .smp       (smp_ch),
    .med       (med_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // window model state
  sample_t win_ring   [MAX_WINDOW];
  sample_t win_sorted [MAX_WINDOW];
  int      win_fill;
  int      win_head;
  cfg_t    win_cfg;

  sample_t median_q [$];
  logic    cur_typed;
  sample_t cur_med;
  int      src_idle;
  int      sink_stall;
  bit      out_hold_req;
  int      errors;
  int      n_words;
  int      n_starts;
  int      n_medians;
  int      n_cfg;
  int      stall_cnt;

  initial clk = 1'b0;
  always #1 clk = ~clk;

  function automatic void window_cfg(cfg_t v);
    win_cfg  = v;
    win_fill = 0;
    win_head = 0;
  endfunction

  function automatic void queue_median(sample_t v);
    median_q.insert(median_q.size(), v);
  endfunction

  function automatic void sorted_put(int n, sample_t v);
    int i;
    i = n;
    while (i > 0 && v < win_sorted[i-1]) begin
      win_sorted[i] = win_sorted[i-1];
      i--;
    end
    win_sorted[i] = v;
  endfunction

  function automatic logic median_step(sample_t s, logic st, output sample_t m);
    int      len;
    int      i;
    sample_t old;
    len = (win_cfg == 0) ? 1 : ((win_cfg > MAX_WINDOW) ? MAX_WINDOW : int'(win_cfg));
    if (st) begin
      win_fill = 0;
      win_head = 0;
    end
    if (win_fill > len) win_fill = len;
    if (win_head >= len) win_head = 0;
    if (win_fill < len) begin
      sorted_put(win_fill, s);
      win_ring[(win_head + win_fill) % len] = s;
      win_fill++;
    end else begin
      old = win_ring[win_head];
      i = 0;
      while (i + 1 < len && win_sorted[i] != old) i++;
      while (i + 1 < len) begin
        win_sorted[i] = win_sorted[i+1];
        i++;
      end
      sorted_put(len - 1, s);
      win_ring[win_head] = s;
      win_head = (win_head + 1) % len;
    end
    m = win_sorted[(len - 1) / 2];
    return win_fill == len;
  endfunction

  task automatic report_bad(string msg);
    errors++;
    if (errors <= 10) $display("%s", msg);
  endtask

  always @(posedge clk) begin
    logic    got;
    logic    progress;
    sample_t pred;
    sample_t want;
    if (rst) begin
      window_cfg(5'd16);
      median_q.delete();
      stall_cnt = 0;
    end else begin
      progress = 1'b0;
      if (med_ch.valid && med_ch.ready) begin
        progress = 1'b1;
        n_medians++;
        if (median_q.size() == 0) begin
          report_bad($sformatf("unexpected median word %0d", med_ch.median_value));
        end else begin
          want = median_q.pop_front();
          if (want !== med_ch.median_value)
            report_bad($sformatf("median mismatch: expected %0d got %0d",
                                 want, med_ch.median_value));
        end
      end
      if (smp_ch.valid && smp_ch.ready) begin
        progress = 1'b1;
        n_words++;
        if (smp_ch.start_req) n_starts++;
        got = median_step(smp_ch.sample, smp_ch.start_req, pred);
        if (cur_typed) queue_median(cur_med);
        else if (got) queue_median(pred);
      end
      if (cfg_we) window_cfg(cfg_wdata);
      stall_cnt = progress ? 0 : stall_cnt + 1;
      if (stall_cnt >= STALL_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // receiver
  initial begin
    med_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (out_hold_req) begin
        out_hold_req = 1'b0;
        med_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else begin
        med_ch.ready <= ($urandom_range(99) >= sink_stall);
      end
    end
  end

  task automatic send_word(sample_t s, logic st, logic typed, sample_t med);
    while ($urandom_range(99) < src_idle) begin
      smp_ch.valid <= 1'b0;
      @(negedge clk);
    end
    smp_ch.valid     <= 1'b1;
    smp_ch.sample    <= s;
    smp_ch.start_req <= st;
    cur_typed        <= typed;
    cur_med          <= med;
    do @(posedge clk); while (!smp_ch.ready);
    @(negedge clk);
  endtask

  task automatic drain_medians();
    smp_ch.valid <= 1'b0;
    while (median_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_window(cfg_t v);
    drain_medians();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we    <= 1'b0;
    n_cfg++;
  endtask

  initial begin
    sample_t s;
    logic    st;
    cfg_t    wl;
    int      seq_left;
    rst              = 1'b1;
    cfg_we           = 1'b0;
    cfg_wdata        = '0;
    smp_ch.valid     = 1'b0;
    smp_ch.sample    = '0;
    smp_ch.start_req = 1'b0;
    cur_typed        = 1'b0;
    cur_med          = '0;
    src_idle         = 0;
    sink_stall       = 0;
    out_hold_req     = 1'b0;
    errors           = 0;
    n_words          = 0;
    n_starts         = 0;
    n_medians        = 0;
    n_cfg            = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (DIR_TAB[i]) begin
      if (DIR_TAB[i].is_cfg) write_window(DIR_TAB[i].win);
      else send_word(DIR_TAB[i].smp, DIR_TAB[i].st, DIR_TAB[i].typed, DIR_TAB[i].med);
    end

    for (int p = 0; p < N_PHASES; p++) begin
      case (p % 4)
        0: begin src_idle = 0;  sink_stall = 0;  end
        1: begin src_idle = 70; sink_stall = 0;  end
        2: begin src_idle = 0;  sink_stall = 70; end
        default: begin src_idle = 17; sink_stall = 17; end
      endcase
      case (p)
        0: wl = 5'd1;
        1: wl = 5'd16;
        2: wl = 5'd0;
        3: wl = 5'd31;
        4: wl = 5'd2;
        5: wl = 5'd17;
        default: wl = cfg_t'($urandom_range(0, 31));
      endcase
      write_window(wl);
      if (p == 0) out_hold_req = 1'b1;
      seq_left = 0;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        st = 1'b0;
        if (seq_left == 0) begin
          st = 1'b1;
          seq_left = $urandom_range(8, 80);
        end
        seq_left--;
        if ($urandom_range(49) == 0) st = 1'b1;
        case ($urandom_range(9))
          6, 7: s = sample_t'(int'($urandom_range(0, 8)) - 4);
          8: s = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
          default: s = sample_t'($urandom());
        endcase
        send_word(s, st, 1'b0, '0);
      end
    end

    drain_medians();
    repeat (10) @(posedge clk);
    $display("covered %0d sample words (%0d with start request), %0d median words",
             n_words, n_starts, n_medians);
    $display("%0d window lengths incl. zero and above range, four idle mixes, %0d-cycle hold-off",
             n_cfg, HOLD_CYCLES);
    if (errors == 0 && median_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/swm_pkg.sv
rtl/core/swm_if.sv
rtl/core/swm_cell.sv
rtl/core/sliding_window_median.sv
rtl/core/swm_checker.sv
tb/sv/tb.sv
